// ----- hdl/sigmoid_neuron_mac_top_macros.svh -----
`ifndef SIGMOID_NEURON_MAC_TOP_MACROS_SVH
`define SIGMOID_NEURON_MAC_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SNM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SNM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/snm_pkg.sv -----
`default_nettype none

package snm_pkg;

  // request codes carried in s_axis_tuser
  typedef enum logic [1:0] {
    REQ_DATA = 2'd0,
    REQ_SET  = 2'd1,
    REQ_ADD  = 2'd2,
    REQ_READ = 2'd3
  } req_e;

  // result kinds carried in m_axis_tuser
  typedef enum logic [1:0] {
    KIND_NEURON = 2'd0,
    KIND_RDATA  = 2'd1,
    KIND_ACK    = 2'd2
  } kind_e;

  // config register indexes
  localparam logic CFG_NUM_INPUTS = 1'b0;
  localparam logic CFG_BIAS       = 1'b1;

  localparam int unsigned NUM_W   = 7;   // num_inputs register
  localparam int unsigned VAL_W   = 16;  // Q4.12 values and weights
  localparam int unsigned WIDX_W  = 6;   // weight_index field
  localparam int unsigned ACC_W   = 40;  // Q16.24 accumulator
  localparam int unsigned PROD_W  = 32;  // Q8.24 product
  localparam int unsigned ARG_W   = 41;  // accumulator minus shifted bias
  localparam int unsigned OFF_W   = 28;  // clamped argument offset, [0, 2^28)
  localparam int unsigned SIG_W   = 16;  // Q0.16 activation
  localparam int unsigned BIAS_SH = 12;  // Q4.12 -> Q.24

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 56;

endpackage

`default_nettype wire

// ----- hdl/sigmoid_neuron_mac_top.sv -----
// An accepted s_axis beat passes the EX, IX and LK registers and the output register to m_axis.
// Throughput: one beat per cycle unless m_axis_tready stalls; the MAC stage, weight store
// and sigmoid table each take a new item every cycle, the store forwards back-to-back writes.
// Reset: rst_ni asynchronous, active low; clears the pipeline, count and
// accumulator, sets num_inputs to 1 and bias to 0. Weights read as zero until
// written (per-entry valid bits), so no clearing pass is needed.
`default_nettype none

module sigmoid_neuron_mac_top #(
  parameter int unsigned MAX_INPUTS      = 64,
  parameter int unsigned SIGMOID_ENTRIES = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config write port
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [snm_pkg::VAL_W-1:0]         cfg_data_i,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [snm_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // weight_index[5:0], value[21:6]
  input  wire logic [1:0]                        s_axis_tuser,  // req_type[1:0]
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [snm_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // activation[15:0],
                                                                // activation_no_bias[31:16],
                                                                // weight_data[47:32],
                                                                // index_error[48]
  output logic [1:0]                             m_axis_tuser   // result_kind[1:0]
);

  // index/count widths follow the weight table depth
  localparam int unsigned AW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int unsigned CNT_NW = $clog2(MAX_INPUTS + 1);
  localparam int unsigned NW     = (CNT_NW > snm_pkg::NUM_W) ? CNT_NW : snm_pkg::NUM_W;
  localparam int unsigned IW     = $clog2(SIGMOID_ENTRIES);
  localparam int unsigned PW     = snm_pkg::OFF_W + IW + 1;

  localparam logic signed [snm_pkg::ARG_W-1:0] ARG_LO = -(41'sd1 <<< 27);
  localparam logic signed [snm_pkg::ARG_W-1:0] ARG_HI = (41'sd1 <<< 27) - 41'sd1;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [snm_pkg::NUM_W-1:0]        num_q;
  logic signed [snm_pkg::VAL_W-1:0] bias_q;
  logic [NW-1:0]                    num_ext;
  logic [NW-1:0]                    n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= snm_pkg::NUM_W'(1);
      bias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        snm_pkg::CFG_NUM_INPUTS: num_q  <= cfg_data_i[snm_pkg::NUM_W-1:0];
        snm_pkg::CFG_BIAS:       bias_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the table depth as the depth
  assign num_ext = NW'(num_q);
  always_comb begin
    if (num_ext == '0) begin
      n_eff = NW'(1);
    end else if (num_ext > NW'(MAX_INPUTS)) begin
      n_eff = NW'(MAX_INPUTS);
    end else begin
      n_eff = num_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Ready chain: each stage loads when empty or when its content moves on
  // ---------------------------------------------------------------------------
  logic out_v_q, lk_v_q, ix_v_q, ex_v_q;
  logic out_free, lk_free, ix_free, ex_free;
  logic in_acc;

  assign out_free      = !out_v_q || m_axis_tready;
  assign lk_free       = !lk_v_q || out_free;
  assign ix_free       = !ix_v_q || lk_free;
  assign ex_free       = !ex_v_q || ix_free;
  assign s_axis_tready = ex_free;
  assign in_acc        = s_axis_tvalid && ex_free;

  // ---------------------------------------------------------------------------
  // Accept: element count, weight store read address
  // ---------------------------------------------------------------------------
  snm_pkg::req_e                    in_req;
  logic [snm_pkg::WIDX_W-1:0]       in_widx;
  logic [snm_pkg::VAL_W-1:0]        in_val;
  logic [AW-1:0]                    cnt_q;
  logic [NW-1:0]                    cnt_inc;
  logic                             in_last;
  logic [AW-1:0]                    rd_addr;

  assign in_req  = snm_pkg::req_e'(s_axis_tuser);
  assign in_widx = s_axis_tdata[snm_pkg::WIDX_W-1:0];
  assign in_val  = s_axis_tdata[snm_pkg::WIDX_W +: snm_pkg::VAL_W];
  assign cnt_inc = NW'(cnt_q) + NW'(1);
  // count may exceed a lowered num_inputs; the next element then completes
  assign in_last = (cnt_inc >= n_eff);
  assign rd_addr = (in_req == snm_pkg::REQ_DATA) ? cnt_q : AW'(in_widx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && (in_req == snm_pkg::REQ_DATA)) begin
      cnt_q <= in_last ? '0 : AW'(cnt_inc);
    end
  end

  // ---------------------------------------------------------------------------
  // EX stage: MAC, weight set / add / read
  // ---------------------------------------------------------------------------
  snm_pkg::req_e                     ex_req_q;
  logic [snm_pkg::WIDX_W-1:0]        ex_widx_q;
  logic signed [snm_pkg::VAL_W-1:0]  ex_val_q;
  logic                              ex_last_q;

  // request code held in reset so the decoder never sees an unknown value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_v_q   <= 1'b0;
      ex_req_q <= snm_pkg::REQ_DATA;
    end else begin
      if (ex_free) begin
        ex_v_q <= s_axis_tvalid;
      end
      if (in_acc) begin
        ex_req_q <= in_req;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_widx_q <= in_widx;
      ex_val_q  <= in_val;
      ex_last_q <= in_last;
    end
  end

  logic signed [snm_pkg::VAL_W-1:0]  w_rd;
  logic                              ex_go;
  logic                              ex_err;
  logic signed [snm_pkg::PROD_W-1:0] prod;
  logic signed [snm_pkg::ACC_W:0]    acc_sum;
  logic signed [snm_pkg::ACC_W-1:0]  acc_sat;
  logic signed [snm_pkg::ACC_W-1:0]  acc_q;
  logic signed [snm_pkg::ACC_W-1:0]  acc_d;
  logic signed [snm_pkg::VAL_W:0]    wsum;
  logic signed [snm_pkg::VAL_W-1:0]  wsum_sat;
  logic                              wr_en;
  logic [snm_pkg::VAL_W-1:0]         wr_data;
  logic                              ix_v_d;
  snm_pkg::kind_e                    ix_kind_d;
  logic signed [snm_pkg::ACC_W-1:0]  ix_sum_d;
  logic [snm_pkg::VAL_W-1:0]         ix_wd_d;
  logic                              ix_err_d;

  snm_wmem #(
    .DEPTH (MAX_INPUTS)
  ) u_wmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (rd_addr),
    .rd_data_o (w_rd),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(ex_widx_q)),
    .wr_data_i (wr_data)
  );

  assign ex_go  = ex_v_q && ix_free;
  assign ex_err = (NW'(ex_widx_q) >= n_eff);

  assign prod    = w_rd * ex_val_q;
  assign acc_sum = {acc_q[snm_pkg::ACC_W-1], acc_q} + (snm_pkg::ACC_W + 1)'(prod);
  // saturate to the 40-bit signed range
  always_comb begin
    if (acc_sum[snm_pkg::ACC_W] != acc_sum[snm_pkg::ACC_W-1]) begin
      acc_sat = acc_sum[snm_pkg::ACC_W] ? {1'b1, {(snm_pkg::ACC_W-1){1'b0}}}
                                        : {1'b0, {(snm_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[snm_pkg::ACC_W-1:0];
    end
  end

  assign wsum = {w_rd[snm_pkg::VAL_W-1], w_rd} + {ex_val_q[snm_pkg::VAL_W-1], ex_val_q};
  always_comb begin
    if (wsum[snm_pkg::VAL_W] != wsum[snm_pkg::VAL_W-1]) begin
      wsum_sat = wsum[snm_pkg::VAL_W] ? {1'b1, {(snm_pkg::VAL_W-1){1'b0}}}
                                      : {1'b0, {(snm_pkg::VAL_W-1){1'b1}}};
    end else begin
      wsum_sat = wsum[snm_pkg::VAL_W-1:0];
    end
  end

  always_comb begin
    acc_d     = acc_q;
    wr_en     = 1'b0;
    wr_data   = ex_val_q;
    ix_v_d    = 1'b0;
    ix_kind_d = snm_pkg::KIND_ACK;
    ix_sum_d  = acc_sat;
    ix_wd_d   = '0;
    ix_err_d  = 1'b0;
    unique case (ex_req_q)
      snm_pkg::REQ_DATA: begin
        ix_kind_d = snm_pkg::KIND_NEURON;
        if (ex_last_q) begin
          ix_v_d = ex_v_q;
          acc_d  = '0;
        end else begin
          acc_d  = acc_sat;
        end
      end
      snm_pkg::REQ_SET: begin
        ix_v_d   = ex_v_q;
        ix_err_d = ex_err;
        wr_en    = ex_go && !ex_err;
        wr_data  = ex_val_q;
      end
      snm_pkg::REQ_ADD: begin
        ix_v_d   = ex_v_q;
        ix_err_d = ex_err;
        wr_en    = ex_go && !ex_err;
        wr_data  = wsum_sat;
      end
      snm_pkg::REQ_READ: begin
        ix_v_d    = ex_v_q;
        ix_kind_d = snm_pkg::KIND_RDATA;
        ix_err_d  = ex_err;
        ix_wd_d   = ex_err ? '0 : w_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ex_go) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // IX stage: bias, clamp to [-8, 8), table index
  // ---------------------------------------------------------------------------
  snm_pkg::kind_e                    ix_kind_q;
  logic signed [snm_pkg::ACC_W-1:0]  ix_sum_q;
  logic [snm_pkg::VAL_W-1:0]         ix_wd_q;
  logic                              ix_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ix_v_q <= 1'b0;
    end else if (ix_free) begin
      ix_v_q <= ix_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ix_free) begin
      ix_kind_q <= ix_kind_d;
      ix_sum_q  <= ix_sum_d;
      ix_wd_q   <= ix_wd_d;
      ix_err_q  <= ix_err_d;
    end
  end

  function automatic logic [IW-1:0] sig_idx(input logic signed [snm_pkg::ARG_W-1:0] x);
    logic [snm_pkg::OFF_W-1:0] off;
    logic [PW-1:0]             scaled;
    if (x < ARG_LO) begin
      off = '0;
    end else if (x > ARG_HI) begin
      off = '1;
    end else begin
      // x + 2^27 for x in range is x with bit 27 flipped
      off = x[snm_pkg::OFF_W-1:0] ^ {1'b1, {(snm_pkg::OFF_W-1){1'b0}}};
    end
    scaled = PW'(off) * PW'(SIGMOID_ENTRIES);
    return scaled[snm_pkg::OFF_W +: IW];
  endfunction

  logic signed [snm_pkg::ARG_W-1:0] bias_sh;
  logic signed [snm_pkg::ARG_W-1:0] arg_n;
  logic signed [snm_pkg::ARG_W-1:0] arg_b;

  assign bias_sh = {{(snm_pkg::ARG_W - snm_pkg::VAL_W - snm_pkg::BIAS_SH){bias_q[snm_pkg::VAL_W-1]}},
                    bias_q, {snm_pkg::BIAS_SH{1'b0}}};
  assign arg_n   = {ix_sum_q[snm_pkg::ACC_W-1], ix_sum_q};
  assign arg_b   = arg_n - bias_sh;

  // ---------------------------------------------------------------------------
  // LK stage: table lookup
  // ---------------------------------------------------------------------------
  snm_pkg::kind_e             lk_kind_q;
  logic [IW-1:0]              lk_idx_b_q;
  logic [IW-1:0]              lk_idx_n_q;
  logic [snm_pkg::VAL_W-1:0]  lk_wd_q;
  logic                       lk_err_q;
  logic [snm_pkg::SIG_W-1:0]  sig_b;
  logic [snm_pkg::SIG_W-1:0]  sig_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_v_q <= 1'b0;
    end else if (lk_free) begin
      lk_v_q <= ix_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_free) begin
      lk_kind_q  <= ix_kind_q;
      lk_idx_b_q <= sig_idx(arg_b);
      lk_idx_n_q <= sig_idx(arg_n);
      lk_wd_q    <= ix_wd_q;
      lk_err_q   <= ix_err_q;
    end
  end

  snm_sig_lut #(
    .ENTRIES (SIGMOID_ENTRIES)
  ) u_sig_lut (
    .idx_a_i (lk_idx_b_q),
    .idx_b_i (lk_idx_n_q),
    .sig_a_o (sig_b),
    .sig_b_o (sig_n)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [snm_pkg::M_TDATA_W-1:0] out_tdata_q;
  logic [1:0]                    out_tuser_q;
  logic [snm_pkg::SIG_W-1:0]     act_b;
  logic [snm_pkg::SIG_W-1:0]     act_n;

  // activations only in neuron outputs
  assign act_b = (lk_kind_q == snm_pkg::KIND_NEURON) ? sig_b : '0;
  assign act_n = (lk_kind_q == snm_pkg::KIND_NEURON) ? sig_n : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= lk_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_tuser_q <= lk_kind_q;
      out_tdata_q <= {{(snm_pkg::M_TDATA_W - 3*snm_pkg::SIG_W - 1){1'b0}},
                      lk_err_q, lk_wd_q, act_n, act_b};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`include "sigmoid_neuron_mac_top_macros.svh"

  `SNM_ASSERT_NEXT(a_acc_clear, ex_go && (ex_req_q == snm_pkg::REQ_DATA) && ex_last_q, acc_q == '0, "accumulator not cleared after completing element")
  `SNM_ASSERT_NOW(a_no_bad_write, wr_en, !ex_err && ex_go, "weight write with bad index or stalled stage")
  `SNM_ASSERT_NOW(a_neuron_clean, ix_v_q && (ix_kind_q == snm_pkg::KIND_NEURON), (ix_wd_q == '0) && !ix_err_q, "neuron output carries weight fields")

endmodule

`default_nettype wire

// ----- hdl/snm_wmem.sv -----
`default_nettype none

// Weight store: registered read, per-entry valid bits (unwritten reads zero),
// write-to-read bypass for a write landing on the same edge as the read.
module snm_wmem #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [AW-1:0]                rd_addr_i,
  output logic signed [snm_pkg::VAL_W-1:0]  rd_data_o,
  input  wire logic                         wr_en_i,
  input  wire logic [AW-1:0]                wr_addr_i,
  input  wire logic [snm_pkg::VAL_W-1:0]    wr_data_i
);

  logic [snm_pkg::VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          vld_q;
  logic [snm_pkg::VAL_W-1:0] rd_q;
  logic                      rd_vld_q;
  logic                      byp_q;
  logic [snm_pkg::VAL_W-1:0] byp_data_q;
  logic                      rd_ok;
  logic                      byp_hit;

  assign rd_ok   = (32'(rd_addr_i) < DEPTH);
  assign byp_hit = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= rd_ok && vld_q[rd_addr_i];
        byp_q    <= byp_hit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/snm_sig_lut.sv -----
`default_nettype none

// Sigmoid table over [-8, 8), built at elaboration, two read ports.
module snm_sig_lut #(
  parameter int unsigned ENTRIES = 1024,
  localparam int unsigned IW = $clog2(ENTRIES)
) (
  input  wire logic [IW-1:0]              idx_a_i,
  input  wire logic [IW-1:0]              idx_b_i,
  output logic [snm_pkg::SIG_W-1:0]       sig_a_o,
  output logic [snm_pkg::SIG_W-1:0]       sig_b_o
);

  typedef logic [snm_pkg::SIG_W-1:0] tab_t [ENTRIES];

  // exp(-|t|) by a 6-term series then eight squarings, 1/(1+e) or e/(1+e) (t < 0) by long division
  function automatic logic [snm_pkg::SIG_W-1:0] sig_entry(input int unsigned i);
    logic [63:0] one;
    logic [63:0] a;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] dvd;
    logic [63:0] rem;
    logic [63:0] q;
    longint      t;
    one  = 64'd1 << 32;
    t    = -(longint'(1) <<< 27) + longint'((64'(i) << 28) / 64'(ENTRIES));
    a    = (t < 0) ? 64'(-t) : 64'(t);
    sum  = one;
    term = one;
    term = (term * a) >> 32;
    sum  = sum - term;
    term = ((term * a) >> 32) / 64'd2;
    sum  = sum + term;
    term = ((term * a) >> 32) / 64'd3;
    sum  = sum - term;
    term = ((term * a) >> 32) / 64'd4;
    sum  = sum + term;
    term = ((term * a) >> 32) / 64'd5;
    sum  = sum - term;
    for (int s = 0; s < 8; s++) begin
      if (sum < one) begin
        sum = (sum * sum) >> 32;
      end
    end
    num = (t >= 0) ? one : sum;
    den = one + sum;
    dvd = (num << 16) + (den >> 1);
    rem = '0;
    q   = '0;
    for (int b = 48; b >= 0; b--) begin
      rem = {rem[62:0], dvd[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return (q > 64'd65535) ? '1 : q[snm_pkg::SIG_W-1:0];
  endfunction

  function automatic tab_t build_tab();
    tab_t tb;
    for (int i = 0; i < ENTRIES; i++) begin
      tb[i] = sig_entry(i);
    end
    return tb;
  endfunction

  localparam tab_t SIG_TAB = build_tab();

  assign sig_a_o = SIG_TAB[idx_a_i];
  assign sig_b_o = SIG_TAB[idx_b_i];

endmodule

`default_nettype wire
